// ----- src/mcf_pkg.sv -----
// Shared types, constants and table functions for the Miller cylindrical
// forward projection. Used by mcf_cordic and miller_cylindrical_forward.
`timescale 1ns / 1ps
`default_nettype none
package mcf_pkg;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_SPHERE_RADIUS    = 2'd0,
        REG_CENTER_LONGITUDE = 2'd1,
        REG_FALSE_EASTING    = 2'd2,
        REG_FALSE_NORTHING   = 2'd3
    } cfg_reg_t;

    localparam logic [23:0] RADIUS_RESET = 24'd6370997;

    // angles in Q29 radians
    localparam logic signed [33:0] PI29     = 34'sd1686629713;
    localparam logic signed [33:0] TWO_PI29 = 34'sd3373259426;
    localparam logic [31:0]        LAT_LIMIT = 32'd843314857;

    // reciprocal of 5 for 32-bit dividends: floor(n / 5) = (n * RECIP5) >> 34
    localparam logic [31:0] RECIP5 = 32'hCCCCCCCD;

    // CORDIC word widths
    localparam int CW = 36;
    localparam int CIRC_STAGES = 30;
    localparam int HYP_STAGES  = 32;

    localparam logic signed [41:0] OUT_MAX = {1'b0, {41{1'b1}}};
    localparam logic signed [41:0] OUT_MIN = {1'b1, {41{1'b0}}};

    // circular arctangent table, Q30
    function automatic logic signed [CW-1:0] atan_q30(input int i);
        logic signed [CW-1:0] v;
        begin
            case (i)
                0: v = 36'sd843314857;
                1: v = 36'sd497837829;
                2: v = 36'sd263043837;
                3: v = 36'sd133525159;
                4: v = 36'sd67021687;
                5: v = 36'sd33543516;
                6: v = 36'sd16775851;
                7: v = 36'sd8388437;
                8: v = 36'sd4194283;
                9: v = 36'sd2097149;
                default: v = CW'(64'sd1 <<< (30 - i));
            endcase
            return v;
        end
    endfunction

    // hyperbolic arctangent table, Q30
    function automatic logic signed [CW-1:0] atanh_q30(input int i);
        logic signed [CW-1:0] v;
        begin
            case (i)
                1: v = 36'sd589812981;
                2: v = 36'sd274247419;
                3: v = 36'sd134923406;
                4: v = 36'sd67196451;
                5: v = 36'sd33565361;
                6: v = 36'sd16778582;
                7: v = 36'sd8388779;
                8: v = 36'sd4194325;
                9: v = 36'sd2097155;
                default: v = CW'(64'sd1 <<< (30 - i));
            endcase
            return v;
        end
    endfunction

    // shift amount of hyperbolic stage k; iterations 4 and 13 run twice
    function automatic int hyp_shift(input int k);
        int s;
        begin
            if (k < 5)
                s = (k < 4) ? k + 1 : 4;
            else if (k < 15)
                s = (k < 14) ? k : 13;
            else
                s = k - 1;
            return s;
        end
    endfunction

    // clamp to the 42-bit signed output range
    function automatic logic signed [41:0] sat42(input logic signed [46:0] v);
        logic signed [41:0] r;
        begin
            if (v > 47'(OUT_MAX))
                r = OUT_MAX;
            else if (v < 47'(OUT_MIN))
                r = OUT_MIN;
            else
                r = v[41:0];
            return r;
        end
    endfunction

endpackage
`default_nettype wire

// ----- src/mcf_cordic.sv -----
// Pipelined CORDIC: circular rotation gives tan(phi) as a ratio, hyperbolic
// vectoring turns it into atanh(tan(phi)). Uses mcf_pkg tables.
`timescale 1ns / 1ps
`default_nettype none
module mcf_cordic (
    input  wire logic                            clk,
    input  wire logic                            en,
    input  wire logic [29:0]                     phi,
    output logic signed [mcf_pkg::CW-1:0]        z
);

    localparam int W = mcf_pkg::CW;
    localparam int NC = mcf_pkg::CIRC_STAGES;
    localparam int NH = mcf_pkg::HYP_STAGES;

    logic signed [W-1:0] cx_reg [0:NC-1];
    logic signed [W-1:0] cy_reg [0:NC-1];
    logic signed [W-1:0] cz_reg [0:NC-1];
    logic signed [W-1:0] hx_reg [0:NH-1];
    logic signed [W-1:0] hy_reg [0:NH-1];
    logic signed [W-1:0] hz_reg [0:NH-1];

    genvar g;

    // circular rotation, one iteration per stage
    for (g = 0; g < NC; g++) begin : g_circ
        logic signed [W-1:0] xi, yi, zi;
        if (g == 0) begin : g_first
            assign xi = W'(64'sd1073741824);
            assign yi = '0;
            assign zi = signed'(W'(phi));
        end
        else begin : g_next
            assign xi = cx_reg[g-1];
            assign yi = cy_reg[g-1];
            assign zi = cz_reg[g-1];
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (zi >= 0)
                begin
                    cx_reg[g] <= xi - (yi >>> g);
                    cy_reg[g] <= yi + (xi >>> g);
                    cz_reg[g] <= zi - mcf_pkg::atan_q30(g);
                end
                else
                begin
                    cx_reg[g] <= xi + (yi >>> g);
                    cy_reg[g] <= yi - (xi >>> g);
                    cz_reg[g] <= zi + mcf_pkg::atan_q30(g);
                end
            end
        end
    end

    // hyperbolic vectoring, one iteration per stage
    for (g = 0; g < NH; g++) begin : g_hyp
        localparam int SH = mcf_pkg::hyp_shift(g);
        logic signed [W-1:0] xi, yi, zi;
        if (g == 0) begin : g_first
            assign xi = cx_reg[NC-1];
            assign yi = cy_reg[NC-1];
            assign zi = '0;
        end
        else begin : g_next
            assign xi = hx_reg[g-1];
            assign yi = hy_reg[g-1];
            assign zi = hz_reg[g-1];
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (yi >= 0)
                begin
                    hx_reg[g] <= xi - (yi >>> SH);
                    hy_reg[g] <= yi - (xi >>> SH);
                    hz_reg[g] <= zi + mcf_pkg::atanh_q30(SH);
                end
                else
                begin
                    hx_reg[g] <= xi + (yi >>> SH);
                    hy_reg[g] <= yi + (xi >>> SH);
                    hz_reg[g] <= zi - mcf_pkg::atanh_q30(SH);
                end
            end
        end
    end

    assign z = hz_reg[NH-1];

endmodule
`default_nettype wire

// ----- src/miller_cylindrical_forward.sv -----
// Miller cylindrical forward projection, sphere, fixed point.
// The pipeline runs through prep, CORDIC and scale stages, in that order.
// Throughput: one point per cycle; the whole pipeline holds while a result
// waits under out_stall. Reset clears valid bits and loads register defaults
// (radius 6370997 m, offsets zero). Depends on mcf_pkg and mcf_cordic.
`timescale 1ns / 1ps
`default_nettype none
module miller_cylindrical_forward (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [39:0]        cfg_data,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic signed [31:0] longitude,
    input  wire logic signed [30:0] latitude,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [41:0]      easting,
    output logic signed [41:0]      northing
);

    localparam int NCOR  = mcf_pkg::CIRC_STAGES + mcf_pkg::HYP_STAGES;
    localparam int DEPTH = NCOR + 6;

    // configuration registers
    logic [23:0]        radius_reg;
    logic signed [31:0] center_reg;
    logic signed [39:0] fe_reg;
    logic signed [39:0] fn_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= mcf_pkg::RADIUS_RESET;
            center_reg <= '0;
            fe_reg     <= '0;
            fn_reg     <= '0;
        end
        else if (cfg_we)
        begin
            unique case (mcf_pkg::cfg_reg_t'(cfg_index))
                mcf_pkg::REG_SPHERE_RADIUS:    radius_reg <= cfg_data[23:0];
                mcf_pkg::REG_CENTER_LONGITUDE: center_reg <= cfg_data[31:0];
                mcf_pkg::REG_FALSE_EASTING:    fe_reg     <= cfg_data;
                mcf_pkg::REG_FALSE_NORTHING:   fn_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    // global advance: pipeline moves unless a result is held
    logic en;
    logic valid_reg [0:DEPTH-1];

    assign en       = !(valid_reg[DEPTH-1] && out_stall);
    assign in_stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
                valid_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            valid_reg[0] <= in_valid;
            for (int i = 1; i < DEPTH; i++)
                valid_reg[i] <= valid_reg[i-1];
        end
    end

    // stage 1: longitude difference, |lat| clamp, 4a+2
    logic signed [33:0] d_reg;
    logic [31:0]        a4_reg;
    logic               neg1_reg;
    logic [31:0]        alat_next;

    always_comb
    begin
        alat_next = latitude[30] ? 32'(-33'(latitude)) : 32'(latitude);
        if (alat_next > mcf_pkg::LAT_LIMIT)
            alat_next = mcf_pkg::LAT_LIMIT;
    end

    // stage 2: wrap to [-pi, pi], reciprocal multiply for /5
    logic signed [33:0] w_reg;
    logic [63:0]        div_reg;
    logic               neg2_reg;
    logic signed [33:0] w_next;

    always_comb
    begin
        if (d_reg > mcf_pkg::PI29)
            w_next = d_reg - mcf_pkg::TWO_PI29;
        else if (d_reg < -mcf_pkg::PI29)
            w_next = d_reg + mcf_pkg::TWO_PI29;
        else
            w_next = d_reg;
    end

    // stage 3: R * d, phi = 0.4 |lat| in Q30
    logic signed [58:0] ep_reg;
    logic [29:0]        phi_reg;
    logic               neg3_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg    <= 34'(longitude) - 34'(center_reg);
            a4_reg   <= {alat_next[29:0], 2'b00} + 32'd2;
            neg1_reg <= latitude[30];
            w_reg    <= w_next;
            div_reg  <= 64'(a4_reg) * 64'(mcf_pkg::RECIP5);
            neg2_reg <= neg1_reg;
            ep_reg   <= 59'(signed'({1'b0, radius_reg})) * 59'(w_reg);
            phi_reg  <= div_reg[63:34];
            neg3_reg <= neg2_reg;
        end
    end

    // CORDIC section
    logic signed [mcf_pkg::CW-1:0] z_cor;

    mcf_cordic u_cordic (
        .clk (clk),
        .en  (en),
        .phi (phi_reg),
        .z   (z_cor)
    );

    // easting product and sign travel alongside the CORDIC
    logic signed [58:0] epd_reg [0:NCOR-1];
    logic               negd_reg [0:NCOR-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            epd_reg[0]  <= ep_reg;
            negd_reg[0] <= neg3_reg;
            for (int i = 1; i < NCOR; i++)
            begin
                epd_reg[i]  <= epd_reg[i-1];
                negd_reg[i] <= negd_reg[i-1];
            end
        end
    end

    // scale stages: R * Z, constant scaling with rounding, offsets, saturate
    logic signed [60:0] nr_reg;
    logic signed [69:0] eq_reg;
    logic               nega_reg;
    logic signed [73:0] nq_reg;
    logic signed [43:0] ev_reg;
    logic               negb_reg;
    logic signed [45:0] nm;
    logic signed [46:0] n_sum;

    assign nm    = 46'(nq_reg >>> 30);
    assign n_sum = 47'(fn_reg) + (negb_reg ? 47'(-nm) : 47'(nm));

    logic signed [41:0] easting_reg;
    logic signed [41:0] northing_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nr_reg       <= 61'(signed'({1'b0, radius_reg})) * 61'(z_cor);
            eq_reg       <= 70'(epd_reg[NCOR-1]) * 70'sd1000 + 70'sd268435456;
            nega_reg     <= negd_reg[NCOR-1];
            nq_reg       <= 74'(nr_reg) * 74'sd2500 + 74'sd536870912;
            ev_reg       <= 44'(fe_reg) + 44'(eq_reg >>> 29);
            negb_reg     <= nega_reg;
            easting_reg  <= mcf_pkg::sat42(47'(ev_reg));
            northing_reg <= mcf_pkg::sat42(n_sum);
        end
    end

    assign out_valid = valid_reg[DEPTH-1];
    assign easting   = easting_reg;
    assign northing  = northing_reg;

endmodule
`default_nettype wire
